@@ sv/sphere_mesh_point_generator_macros.svh @@
// Assertion macros for the sphere mesh point generator
`ifndef SPHERE_MESH_POINT_GENERATOR_MACROS_SVH
`define SPHERE_MESH_POINT_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SMPG_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("smpg: same-cycle check failed");
`define SMPG_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("smpg: next-cycle check failed");
`else
`define SMPG_ASSERT_NOW(lbl, pre, post)
`define SMPG_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

@@ sv/smpg_pkg.sv @@
package smpg_pkg;

  localparam int MAX_POINTS_DEF   = 256;
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int ATAN_LEN         = 24;

  localparam int CNT_W     = 9;
  localparam int IDX_W     = 8;
  localparam int QW        = 17;   // u, v0, tex fields
  localparam int DIVD_W    = 24;   // dividend / remainder
  localparam int DIV_STEPS = 17;
  localparam int SQ_N_W    = 33;   // radicand
  localparam int SQ_STEPS  = 17;
  localparam int CW        = 34;   // CORDIC datapath
  localparam int POS_W     = 24;
  localparam int NORM_W    = 16;
  localparam int TRI_W     = 16;
  localparam int PROD_W    = 52;
  localparam int RP_W      = 33;

  localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_AZI_POINTS, REG_ALT_POINTS, REG_RADIUS, REG_CENTRE_X, REG_CENTRE_Y, REG_CENTRE_Z
  } reg_idx_t;

  typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

  typedef enum logic [1:0] {PH_VERT, PH_TRI0, PH_TRI1} phase_t;

  // sideband carried down the pipeline; fields fill in as they become known
  typedef struct packed {
    logic [IDX_W-1:0]         azi;
    logic [IDX_W-1:0]         alt;
    logic [QW-1:0]            u;
    logic signed [17:0]       yq;
    logic signed [NORM_W-1:0] ny;
    logic [QW-1:0]            s16;
    quad_t                    quad;
  } side_t;

  // arctangent in 2^32 per turn
  function automatic logic signed [CW-1:0] atan_turn(input int i);
    logic signed [CW-1:0] r;
    unique case (i)
      0:  r = 34'sd536870912;
      1:  r = 34'sd316933406;
      2:  r = 34'sd167458907;
      3:  r = 34'sd85004756;
      4:  r = 34'sd42667331;
      5:  r = 34'sd21354465;
      6:  r = 34'sd10679838;
      7:  r = 34'sd5340245;
      8:  r = 34'sd2670163;
      9:  r = 34'sd1335087;
      10: r = 34'sd667544;
      11: r = 34'sd333772;
      12: r = 34'sd166886;
      13: r = 34'sd83443;
      14: r = 34'sd41722;
      15: r = 34'sd20861;
      16: r = 34'sd10430;
      17: r = 34'sd5215;
      18: r = 34'sd2608;
      19: r = 34'sd1304;
      20: r = 34'sd652;
      21: r = 34'sd326;
      22: r = 34'sd163;
      23: r = 34'sd81;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

@@ sv/smpg_div_cell.sv @@
module smpg_div_cell #(
  parameter int BIT = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [smpg_pkg::DIVD_W-1:0]   rem_in,
  input  logic [smpg_pkg::CNT_W-1:0]    d_in,
  input  logic [smpg_pkg::QW-1:0]       q_in,
  output logic [smpg_pkg::DIVD_W-1:0]   rem_out,
  output logic [smpg_pkg::CNT_W-1:0]    d_out,
  output logic [smpg_pkg::QW-1:0]       q_out
);
  import smpg_pkg::*;

  localparam int RW = DIVD_W + 1;

  logic [RW-1:0] dsh;
  logic          take;

  // one restoring-division quotient bit
  assign dsh  = RW'(d_in) << BIT;
  assign take = {1'b0, rem_in} >= dsh;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out <= take ? rem_in - dsh[DIVD_W-1:0] : rem_in;
      q_out   <= take ? (q_in | (QW'(1) << BIT)) : q_in;
      d_out   <= d_in;
    end
  end

endmodule

@@ sv/smpg_sqrt_cell.sv @@
module smpg_sqrt_cell #(
  parameter int BIT = 0
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic [smpg_pkg::SQ_N_W-1:0]   rem_in,
  input  logic [smpg_pkg::QW-1:0]       root_in,
  output logic [smpg_pkg::SQ_N_W-1:0]   rem_out,
  output logic [smpg_pkg::QW-1:0]       root_out
);
  import smpg_pkg::*;

  localparam int TW = SQ_N_W + 3;

  logic [TW-1:0] trial;
  logic          take;

  // (root + 2^b)^2 - root^2
  assign trial = (TW'(root_in) << (BIT + 1)) + (TW'(1) << (2 * BIT));
  assign take  = TW'(rem_in) >= trial;

  always_ff @(posedge clk) begin
    if (en) begin
      rem_out  <= take ? rem_in - trial[SQ_N_W-1:0] : rem_in;
      root_out <= take ? (root_in | (QW'(1) << BIT)) : root_in;
    end
  end

endmodule

@@ sv/smpg_cordic_cell.sv @@
module smpg_cordic_cell #(
  parameter int STEP      = 0,
  parameter bit VECTORING = 1'b0
) (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [smpg_pkg::CW-1:0]   x_in,
  input  logic signed [smpg_pkg::CW-1:0]   y_in,
  input  logic signed [smpg_pkg::CW-1:0]   z_in,
  output logic signed [smpg_pkg::CW-1:0]   x_out,
  output logic signed [smpg_pkg::CW-1:0]   y_out,
  output logic signed [smpg_pkg::CW-1:0]   z_out
);
  import smpg_pkg::*;

  logic signed [CW-1:0] xs, ys, at;
  logic                 ccw;

  assign xs  = x_in >>> STEP;
  assign ys  = y_in >>> STEP;
  assign at  = atan_turn(STEP);
  // vectoring drives y to zero, rotation drives z to zero
  assign ccw = VECTORING ? (y_in < 0) : (z_in >= 0);

  always_ff @(posedge clk) begin
    if (en) begin
      x_out <= ccw ? x_in - ys : x_in + ys;
      y_out <= ccw ? y_in + xs : y_in - xs;
      z_out <= ccw ? z_in - at : z_in + at;
    end
  end

endmodule

@@ sv/sphere_mesh_point_generator.sv @@
// UV-sphere mesh point generator.
// Request channel: azimuth_index / altitude_index with point_valid, point_stall.
// Result channel: position, normal, texture, triangle indices and last, with
//   vertex_valid, vertex_stall. Each grid point yields a vertex result and,
//   unless it lies on the last row, two triangle results; last marks the end.
// Config: APB-style, register i at byte address 4*i, pready tied high.
// Pipeline: input register, 17 divider cells (u and v0 side by side), a
//   square stage, 17 square-root cells, a CORDIC setup stage, CORDIC_STEPS
//   cells of vectoring and rotation CORDIC side by side, a multiply stage,
//   a normal/radius multiply stage, then the result register.
// Throughput: one request per cycle on the last row while vertex_stall is low;
//   on other rows a request waits until all three results of the point are taken,
//   as the result port emits one result per cycle when not stalled.
// The whole pipeline advances together; when the result register holds a
//   result that is stalled, or more results of the same point remain,
//   point_stall is raised and every stage holds.
// Reset clears the valid line and result state and holds point_stall high;
//   config returns to defaults.
module sphere_mesh_point_generator #(
  parameter int CORDIC_STEPS = smpg_pkg::CORDIC_STEPS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // APB config
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [4:0]                            paddr,
  input  logic [31:0]                           pwdata,
  output logic [31:0]                           prdata,
  output logic                                  pready,
  // request
  input  logic                                  point_valid,
  output logic                                  point_stall,
  input  logic [smpg_pkg::IDX_W-1:0]            azimuth_index,
  input  logic [smpg_pkg::IDX_W-1:0]            altitude_index,
  // result
  output logic                                  vertex_valid,
  input  logic                                  vertex_stall,
  output logic signed [smpg_pkg::POS_W-1:0]     pos_x,
  output logic signed [smpg_pkg::POS_W-1:0]     pos_y,
  output logic signed [smpg_pkg::POS_W-1:0]     pos_z,
  output logic signed [smpg_pkg::NORM_W-1:0]    norm_x,
  output logic signed [smpg_pkg::NORM_W-1:0]    norm_y,
  output logic signed [smpg_pkg::NORM_W-1:0]    norm_z,
  output logic [smpg_pkg::QW-1:0]               tex_u,
  output logic [smpg_pkg::QW-1:0]               tex_v,
  output logic [smpg_pkg::TRI_W-1:0]            tri_a,
  output logic [smpg_pkg::TRI_W-1:0]            tri_b,
  output logic [smpg_pkg::TRI_W-1:0]            tri_c,
  output logic                                  last
);
  import smpg_pkg::*;

  `include "sphere_mesh_point_generator_macros.svh"

  // stage numbering of the valid/sideband line
  localparam int S_M1 = DIV_STEPS + 1;
  localparam int S_P  = S_M1 + SQ_STEPS + 1;
  localparam int S_X  = S_P + CORDIC_STEPS + 1;
  localparam int S_Y  = S_X + 1;
  localparam int NST  = S_Y + 1;

  // ---------------- config registers ----------------
  logic [CNT_W-1:0]        azimuth_points, altitude_points;
  logic [15:0]             radius;
  logic signed [POS_W-1:0] centre_x, centre_y, centre_z;
  reg_idx_t                widx;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      azimuth_points  <= CNT_W'(16);
      altitude_points <= CNT_W'(16);
      radius          <= 16'd256;
      centre_x        <= '0;
      centre_y        <= '0;
      centre_z        <= '0;
    end else if (psel && penable && pwrite && pready) begin
      unique case (widx)
        REG_AZI_POINTS: azimuth_points  <= pwdata[CNT_W-1:0];
        REG_ALT_POINTS: altitude_points <= pwdata[CNT_W-1:0];
        REG_RADIUS:     radius          <= pwdata[15:0];
        REG_CENTRE_X:   centre_x        <= pwdata[POS_W-1:0];
        REG_CENTRE_Y:   centre_y        <= pwdata[POS_W-1:0];
        REG_CENTRE_Z:   centre_z        <= pwdata[POS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (widx)
      REG_AZI_POINTS: prdata = 32'(azimuth_points);
      REG_ALT_POINTS: prdata = 32'(altitude_points);
      REG_RADIUS:     prdata = 32'(radius);
      REG_CENTRE_X:   prdata = 32'(centre_x);
      REG_CENTRE_Y:   prdata = 32'(centre_y);
      REG_CENTRE_Z:   prdata = 32'(centre_z);
      default:        prdata = '0;
    endcase
  end

  // effective grid counts, clamped to [2, MAX_POINTS_DEF]
  function automatic logic [CNT_W-1:0] eff_count(input logic [CNT_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v < CNT_W'(2))                r = CNT_W'(2);
    else if (32'(v) > MAX_POINTS_DEF) r = CNT_W'(MAX_POINTS_DEF);
    else                              r = v;
    return r;
  endfunction

  logic [CNT_W-1:0] dna, dnl, nl;
  assign nl  = eff_count(altitude_points);
  assign dna = eff_count(azimuth_points) - CNT_W'(1);
  assign dnl = nl - CNT_W'(1);

  // ---------------- flow control ----------------
  logic   adv, out_take, done, more;
  logic [NST-1:0] vld;
  phase_t phase, phase_next;

  assign out_take    = vertex_valid && !vertex_stall;
  assign done        = out_take && last;
  assign adv         = !vertex_valid || done;
  assign point_stall = rst || !adv;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (adv) vld <= {vld[NST-2:0], point_valid};
  end

  // ---------------- sideband line ----------------
  side_t side      [0:NST-1];
  side_t side_next [0:NST-1];

  // ---------------- stage 0: clamp, dividends ----------------
  logic [IDX_W-1:0]  azi_c, alt_c;
  logic [DIVD_W-1:0] du_rem [0:DIV_STEPS];
  logic [DIVD_W-1:0] dv_rem [0:DIV_STEPS];
  logic [CNT_W-1:0]  du_d   [0:DIV_STEPS];
  logic [CNT_W-1:0]  dv_d   [0:DIV_STEPS];
  logic [QW-1:0]     du_q   [0:DIV_STEPS];
  logic [QW-1:0]     dv_q   [0:DIV_STEPS];

  assign azi_c = (CNT_W'(azimuth_index) > dna) ? dna[IDX_W-1:0] : azimuth_index;
  assign alt_c = (CNT_W'(altitude_index) > dnl) ? dnl[IDX_W-1:0] : altitude_index;

  always_ff @(posedge clk) begin
    if (adv) begin
      // rounded quotient: (idx*65536 + d/2) / d
      du_rem[0] <= {azi_c, 16'b0} + DIVD_W'(dna >> 1);
      dv_rem[0] <= {alt_c, 16'b0} + DIVD_W'(dnl >> 1);
      du_d[0]   <= dna;
      dv_d[0]   <= dnl;
      du_q[0]   <= '0;
      dv_q[0]   <= '0;
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_div
    smpg_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_div_u (
      .clk(clk), .en(adv),
      .rem_in(du_rem[k]), .d_in(du_d[k]), .q_in(du_q[k]),
      .rem_out(du_rem[k+1]), .d_out(du_d[k+1]), .q_out(du_q[k+1])
    );
    smpg_div_cell #(.BIT(DIV_STEPS - 1 - k)) u_div_v (
      .clk(clk), .en(adv),
      .rem_in(dv_rem[k]), .d_in(dv_d[k]), .q_in(dv_q[k]),
      .rem_out(dv_rem[k+1]), .d_out(dv_d[k+1]), .q_out(dv_q[k+1])
    );
  end

  // ---------------- M1: yq, ny, radicand ----------------
  logic [QW-1:0]      vq;
  logic signed [18:0] yq_w, ny_w;
  logic signed [17:0] yq_c;
  logic signed [35:0] yq_sq;
  logic signed [36:0] n_full;
  logic [SQ_N_W-1:0]  sq_rem  [0:SQ_STEPS];
  logic [QW-1:0]      sq_root [0:SQ_STEPS];

  assign vq     = dv_q[DIV_STEPS];
  assign yq_w   = 19'sd65536 - $signed({1'b0, vq, 1'b0});
  assign yq_c   = 18'(yq_w);
  assign yq_sq  = yq_c * yq_c;
  assign n_full = 37'sd4294967296 - yq_sq;
  assign ny_w   = 19'sd16384 - $signed({2'b0, QW'((18'(vq) + 18'd1) >> 1)});

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_rem[0]  <= n_full[SQ_N_W-1:0];
      sq_root[0] <= '0;
    end
  end

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    smpg_sqrt_cell #(.BIT(SQ_STEPS - 1 - k)) u_sqrt (
      .clk(clk), .en(adv),
      .rem_in(sq_rem[k]), .root_in(sq_root[k]),
      .rem_out(sq_rem[k+1]), .root_out(sq_root[k+1])
    );
  end

  // ---------------- P: CORDIC setup ----------------
  logic signed [CW-1:0] vx [0:CORDIC_STEPS];
  logic signed [CW-1:0] vy [0:CORDIC_STEPS];
  logic signed [CW-1:0] vz [0:CORDIC_STEPS];
  logic signed [CW-1:0] rx [0:CORDIC_STEPS];
  logic signed [CW-1:0] ry [0:CORDIC_STEPS];
  logic signed [CW-1:0] rz [0:CORDIC_STEPS];
  logic signed [CW-1:0] xv, yv;
  logic [32:0]          ang_in;

  assign xv     = CW'(side[S_P-1].yq) <<< 14;
  assign yv     = CW'({sq_root[SQ_STEPS], 14'b0});
  assign ang_in = {side[S_P-1].u, 16'b0};

  always_ff @(posedge clk) begin
    if (adv) begin
      // left half plane: turn by -90 degrees, start at a quarter turn
      if (side[S_P-1].yq < 0) begin
        vx[0] <= yv;
        vy[0] <= -xv;
        vz[0] <= CW'(34'sd1073741824);
      end else begin
        vx[0] <= xv;
        vy[0] <= yv;
        vz[0] <= '0;
      end
      rx[0] <= CORDIC_GAIN;
      ry[0] <= '0;
      rz[0] <= CW'(ang_in[29:0]);
    end
  end

  for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
    smpg_cordic_cell #(.STEP(k), .VECTORING(1'b1)) u_vec (
      .clk(clk), .en(adv),
      .x_in(vx[k]), .y_in(vy[k]), .z_in(vz[k]),
      .x_out(vx[k+1]), .y_out(vy[k+1]), .z_out(vz[k+1])
    );
    smpg_cordic_cell #(.STEP(k), .VECTORING(1'b0)) u_rot (
      .clk(clk), .en(adv),
      .x_in(rx[k]), .y_in(ry[k]), .z_in(rz[k]),
      .x_out(rx[k+1]), .y_out(ry[k+1]), .z_out(rz[k+1])
    );
  end

  // sideband line with fields filled in at their stages
  always_comb begin
    side_next[0].azi  = azi_c;
    side_next[0].alt  = alt_c;
    side_next[0].u    = '0;
    side_next[0].yq   = '0;
    side_next[0].ny   = '0;
    side_next[0].s16  = '0;
    side_next[0].quad = QUAD_0;
    for (int k = 0; k < NST - 1; k++) side_next[k+1] = side[k];
    side_next[S_M1].u    = du_q[DIV_STEPS];
    side_next[S_M1].yq   = yq_c;
    side_next[S_M1].ny   = NORM_W'(ny_w);
    side_next[S_P].s16   = sq_root[SQ_STEPS];
    side_next[S_P].quad  = quad_t'(ang_in[31:30]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < NST; k++) side[k] <= side_next[k];
    end
  end

  // ---------------- X: quadrant, s16 products, tex_v ----------------
  logic signed [CW-1:0]     cs_c, cs_s, zv;
  logic [32:0]              ang;
  logic signed [PROD_W-1:0] prod_x, prod_z;
  logic [QW-1:0]            tv_x;

  always_comb begin
    unique case (side[S_X-1].quad)
      QUAD_0: begin cs_c = rx[CORDIC_STEPS];  cs_s = ry[CORDIC_STEPS];  end
      QUAD_1: begin cs_c = -ry[CORDIC_STEPS]; cs_s = rx[CORDIC_STEPS];  end
      QUAD_2: begin cs_c = -rx[CORDIC_STEPS]; cs_s = -ry[CORDIC_STEPS]; end
      QUAD_3: begin cs_c = ry[CORDIC_STEPS];  cs_s = -rx[CORDIC_STEPS]; end
      default: begin cs_c = '0; cs_s = '0; end
    endcase
    zv = vz[CORDIC_STEPS];
    if (zv < 0)                        ang = '0;
    else if (zv > 34'sd2147483648)     ang = 33'h1_0000_0000 >> 1;
    else                               ang = zv[32:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      prod_x <= cs_c * $signed({1'b0, side[S_X-1].s16});
      prod_z <= cs_s * $signed({1'b0, side[S_X-1].s16});
      tv_x   <= QW'((ang + 33'd16384) >> 15);
    end
  end

  // ---------------- Y: normal clamp, radius products ----------------
  function automatic logic signed [NORM_W-1:0] norm_clamp(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    logic signed [NORM_W-1:0] r;
    t = (p + 52'sd2147483648) >>> 32;
    if (t > 52'sd16384)       r = 16'sd16384;
    else if (t < -52'sd16384) r = -16'sd16384;
    else                      r = NORM_W'(t);
    return r;
  endfunction

  logic signed [NORM_W-1:0] nx_c, nz_c, nx_y, nz_y;
  logic signed [RP_W-1:0]   rp_x, rp_y, rp_z;
  logic [QW-1:0]            tv_y;
  logic signed [16:0]       rad_s;

  assign nx_c  = norm_clamp(prod_x);
  assign nz_c  = norm_clamp(prod_z);
  assign rad_s = $signed({1'b0, radius});

  always_ff @(posedge clk) begin
    if (adv) begin
      nx_y <= nx_c;
      nz_y <= nz_c;
      rp_x <= rad_s * nx_c;
      rp_y <= rad_s * side[S_Y-1].ny;
      rp_z <= rad_s * nz_c;
      tv_y <= tv_x;
    end
  end

  // ---------------- Z: position, triangle indices, result register ----------
  function automatic logic signed [POS_W-1:0] pos_sat(input logic signed [RP_W-1:0] rp,
                                                      input logic signed [POS_W-1:0] c);
    logic signed [RP_W:0] t;
    logic signed [RP_W:0] s;
    logic signed [POS_W-1:0] r;
    t = (rp + 34'sd8192) >>> 14;
    s = t + c;
    if (s > 34'sd8388607)       r = 24'sd8388607;
    else if (s < -34'sd8388608) r = -24'sd8388608;
    else                        r = POS_W'(s);
    return r;
  endfunction

  logic [CNT_W-1:0] nxt;
  logic [17:0]      nxt_row, azi_row;
  logic [TRI_W-1:0] t_an, t_a1, t_a0, t_n0;

  assign nxt     = (CNT_W'(side[S_Y].azi) < dna) ? CNT_W'(side[S_Y].azi) + CNT_W'(1) : '0;
  assign nxt_row = 18'(nxt) * 18'(nl);
  assign azi_row = 18'(side[S_Y].azi) * 18'(nl);

  always_ff @(posedge clk) begin
    if (adv) begin
      pos_x  <= pos_sat(rp_x, centre_x);
      pos_y  <= pos_sat(rp_y, centre_y);
      pos_z  <= pos_sat(rp_z, centre_z);
      norm_x <= nx_y;
      norm_y <= side[S_Y].ny;
      norm_z <= nz_y;
      tex_u  <= side[S_Y].u;
      tex_v  <= tv_y;
      more   <= CNT_W'(side[S_Y].alt) < dnl;
      t_an   <= TRI_W'(nxt_row + 18'(side[S_Y].alt) + 18'd1);
      t_a1   <= TRI_W'(azi_row + 18'(side[S_Y].alt) + 18'd1);
      t_a0   <= TRI_W'(azi_row + 18'(side[S_Y].alt));
      t_n0   <= TRI_W'(nxt_row + 18'(side[S_Y].alt));
    end
  end

  // result sequencing: vertex, then two triangles unless on the last row
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_valid <= 1'b0;
      phase        <= PH_VERT;
    end else begin
      phase <= phase_next;
      if (adv) vertex_valid <= vld[NST-1];
    end
  end

  always_comb begin
    phase_next = phase;
    tri_a      = '0;
    tri_b      = '0;
    tri_c      = '0;
    last       = !more;
    unique case (phase)
      PH_VERT: begin
        if (out_take && more) phase_next = PH_TRI0;
      end
      PH_TRI0: begin
        tri_a = t_an;
        tri_b = t_a1;
        tri_c = t_a0;
        last  = 1'b0;
        if (out_take) phase_next = PH_TRI1;
      end
      PH_TRI1: begin
        tri_a = t_n0;
        tri_b = t_an;
        tri_c = t_a0;
        last  = 1'b1;
        if (out_take) phase_next = PH_VERT;
      end
      default: phase_next = PH_VERT;
    endcase
    if (adv) phase_next = PH_VERT;
  end

  `SMPG_ASSERT_NEXT(a_more_follows, vertex_valid && !vertex_stall && !last, vertex_valid)
  `SMPG_ASSERT_NEXT(a_phase_holds, vertex_valid && vertex_stall, $stable(phase))
  `SMPG_ASSERT_NOW(a_tri_only_if_more, vertex_valid && phase != PH_VERT, more)
  `SMPG_ASSERT_NOW(a_last_row_single, vertex_valid && !more, last && phase == PH_VERT)

endmodule
